>>> rtl/jrmad_pkg.sv
// Package for the jump-removal moving-average detrend filter.
// Holds widths, register codes, reset values, the sequencer state type,
// divider types and the 24-bit saturation function. Depends on nothing.
`default_nettype none

package jrmad_pkg;

  localparam int LONG_DEPTH_DEF   = 256;
  localparam int SHORT_DEPTH_DEF  = 16;
  localparam int ANALYSIS_MAX_DEF = 1024;

  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 24;
  localparam int THR_W      = 23;
  localparam int LLEN_W     = 8;
  localparam int SLEN_W     = 4;
  localparam int ALEN_W     = 11;
  localparam int CFG_W      = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int LSUM_W     = 32;
  localparam int SSUM_W     = 28;
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 8;
  localparam int MEAN_W     = 25;
  localparam int WIDE_W     = 26;

  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANALYSIS_LEN = 2'd3;

  localparam logic [THR_W-1:0]  JUMP_THR_RST     = 23'd1000;
  localparam logic [LLEN_W-1:0] LONG_LEN_RST     = 8'd51;
  localparam logic [SLEN_W-1:0] SHORT_LEN_RST    = 4'd5;
  localparam logic [ALEN_W-1:0] ANALYSIS_LEN_RST = 11'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_JUMP,
    ST_OFFS,
    ST_LUPD,
    ST_MID,
    ST_MIDCAP,
    ST_LDIV,
    ST_X2,
    ST_SUPD,
    ST_SDIV,
    ST_SWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                          start;
    logic signed [DIVIDEND_W-1:0]  dividend;
    logic [DIVISOR_W-1:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                      valid;
    logic signed [MEAN_W-1:0]  quotient;
  } div_rsp_t;

  function automatic logic signed [VALUE_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VALUE_W:0] hi;
    hi = v[WIDE_W-1:VALUE_W-1];
    if (hi == '0 || hi == '1) begin
      return v[VALUE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/jrmad_ram.sv
// Ring storage for the filter: one write port, one registered read port.
// Depends on jrmad_pkg for default widths.
`default_nettype none

module jrmad_ram import jrmad_pkg::*; #(
  parameter int DEPTH = LONG_DEPTH_DEF,
  parameter int WIDTH = VALUE_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/jrmad_div.sv
// Shared signed divider, two quotient bits per cycle, truncating toward zero.
// Serves both the long and the short window means. Depends on jrmad_pkg.
`default_nettype none

module jrmad_div import jrmad_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEPS = DIVIDEND_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic                     busy;
  logic                     fix;
  logic                     valid;
  logic [CNT_W-1:0]         cnt;
  logic                     neg;
  logic [DIVIDEND_W-1:0]    q;
  logic [DIVISOR_W-1:0]     rem;
  logic [DIVISOR_W-1:0]     dsr;
  logic signed [MEAN_W-1:0] quot;

  logic [DIVISOR_W:0] r1;
  logic [DIVISOR_W:0] r1s;
  logic [DIVISOR_W:0] r2;
  logic [DIVISOR_W:0] r2s;
  logic               b1;
  logic               b2;

  always_comb begin
    r1  = {rem, q[DIVIDEND_W-1]};
    b1  = r1 >= {1'b0, dsr};
    r1s = b1 ? r1 - {1'b0, dsr} : r1;
    r2  = {r1s[DIVISOR_W-1:0], q[DIVIDEND_W-2]};
    b2  = r2 >= {1'b0, dsr};
    r2s = b2 ? r2 - {1'b0, dsr} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fix   <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      fix   <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end
    end else if (fix) begin
      fix   <= 1'b0;
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[DIVIDEND_W-1];
      q   <= req.dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-req.dividend) : req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      q   <= {q[DIVIDEND_W-3:0], b1, b2};
      rem <= r2s[DIVISOR_W-1:0];
    end else if (fix) begin
      quot <= neg ? -$signed(q[MEAN_W-1:0]) : $signed(q[MEAN_W-1:0]);
    end
  end

  assign rsp = '{valid: valid, quotient: quot};

endmodule

`default_nettype wire

>>> rtl/jump_removal_moving_average_detrend.sv
// Jump removal, centred long-mean detrend and short moving average.
// A sample is taken only in idle, and the next one only once the block is
// back in idle. While the long ring fills, a sample ends after the long
// update with no result; while the short ring fills, after the short update.
// The means share one divider; an unaccepted result holds the next one back.
// Synchronous reset restores register defaults and empties both rings.
`default_nettype none

module jump_removal_moving_average_detrend import jrmad_pkg::*; #(
  parameter int LONG_DEPTH   = LONG_DEPTH_DEF,
  parameter int SHORT_DEPTH  = SHORT_DEPTH_DEF,
  parameter int ANALYSIS_MAX = ANALYSIS_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [VALUE_W-1:0]   m_tdata,   // [23:0] filtered_value
  output logic                      m_tuser,   // [0] window_ready
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int LP_W = $clog2(LONG_DEPTH);
  localparam int SP_W = $clog2(SHORT_DEPTH);

  state_t state;
  state_t state_next;

  logic [THR_W-1:0]  jump_thr;
  logic [LLEN_W-1:0] long_len;
  logic [SLEN_W-1:0] short_len;
  logic [ALEN_W-1:0] analysis_len;

  logic [LLEN_W-1:0] l_eff;
  logic [SLEN_W-1:0] s_eff;
  logic [ALEN_W-1:0] a_eff;

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] prev;
  logic                       have_prev;
  logic                       pass;
  logic signed [VALUE_W-1:0]  jump_offset;
  logic signed [VALUE_W-1:0]  x1;
  logic signed [VALUE_W-1:0]  mid_val;
  logic signed [VALUE_W-1:0]  x2;

  logic [LLEN_W-1:0]        lfill;
  logic [LLEN_W-1:0]        lptr;
  logic signed [LSUM_W-1:0] lsum;
  logic [SLEN_W-1:0]        sfill;
  logic [SLEN_W-1:0]        sptr;
  logic signed [SSUM_W-1:0] ssum;
  logic [ALEN_W-1:0]        pc;
  logic                     ready_flag;
  logic signed [VALUE_W-1:0] x3;

  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]        mag;
  logic [LLEN_W-1:0]        lfill_inc;
  logic [LLEN_W-1:0]        lptr_inc;
  logic                     lfull;
  logic                     lfull_next;
  logic [LLEN_W-1:0]        l_half;
  logic [LLEN_W:0]          mid_sum;
  logic [LLEN_W-1:0]        mid;
  logic [SLEN_W-1:0]        sfill_inc;
  logic [SLEN_W-1:0]        sptr_inc;
  logic                     sfull;
  logic                     sfull_next;
  logic [ALEN_W-1:0]        pc_inc;
  logic                     pc_open;
  logic                     ready_next;
  logic                     out_load;

  logic                      long_we;
  logic                      long_re;
  logic [LP_W-1:0]           long_raddr;
  logic [VALUE_W-1:0]        long_rdata;
  logic                      short_we;
  logic                      short_re;
  logic [VALUE_W-1:0]        short_rdata;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  always_comb begin
    if (long_len == '0) begin
      l_eff = LLEN_W'(1);
    end else if (int'(long_len) > LONG_DEPTH) begin
      l_eff = LLEN_W'(LONG_DEPTH);
    end else begin
      l_eff = long_len;
    end
    if (short_len == '0) begin
      s_eff = SLEN_W'(1);
    end else if (int'(short_len) > SHORT_DEPTH) begin
      s_eff = SLEN_W'(SHORT_DEPTH);
    end else begin
      s_eff = short_len;
    end
    if (analysis_len == '0) begin
      a_eff = ALEN_W'(1);
    end else if (int'(analysis_len) > ANALYSIS_MAX) begin
      a_eff = ALEN_W'(ANALYSIS_MAX);
    end else begin
      a_eff = analysis_len;
    end
  end

  always_comb begin
    diff       = (SAMPLE_W + 1)'(sample) - (SAMPLE_W + 1)'(prev);
    mag        = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : diff;
    lfill_inc  = lfill + 1'b1;
    lptr_inc   = lptr + 1'b1;
    lfull      = lfill == l_eff;
    lfull_next = lfull || (lfill_inc == l_eff);
    l_half     = (l_eff - 1'b1) >> 1;
    mid_sum    = (LLEN_W + 1)'(lptr) + (LLEN_W + 1)'(l_half);
    mid        = (mid_sum >= (LLEN_W + 1)'(l_eff)) ?
                 LLEN_W'(mid_sum - (LLEN_W + 1)'(l_eff)) : LLEN_W'(mid_sum);
    sfill_inc  = sfill + 1'b1;
    sptr_inc   = sptr + 1'b1;
    sfull      = sfill == s_eff;
    sfull_next = sfull || (sfill_inc == s_eff);
    pc_inc     = pc + 1'b1;
    pc_open    = pc < a_eff;
    ready_next = ready_flag || (pc_open && (pc_inc >= a_eff));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_JUMP;
      ST_JUMP:   state_next = ST_OFFS;
      ST_OFFS:   state_next = ST_LUPD;
      ST_LUPD:   state_next = lfull_next ? ST_MID : ST_IDLE;
      ST_MID:    state_next = ST_MIDCAP;
      ST_MIDCAP: state_next = ST_LDIV;
      ST_LDIV:   if (div_rsp.valid) state_next = ST_X2;
      ST_X2:     state_next = ST_SUPD;
      ST_SUPD:   state_next = sfull_next ? ST_SDIV : ST_IDLE;
      ST_SDIV:   state_next = ST_SWAIT;
      ST_SWAIT:  if (div_rsp.valid) state_next = ST_OUT;
      ST_OUT:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = 1'b0;
    long_we          = 1'b0;
    long_re          = 1'b0;
    long_raddr       = LP_W'(lptr);
    short_we         = 1'b0;
    short_re         = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = lsum;
    div_req.divisor  = l_eff;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_OFFS: long_re  = 1'b1;
      ST_LUPD: long_we  = 1'b1;
      ST_MID: begin
        long_re       = 1'b1;
        long_raddr    = LP_W'(mid);
        div_req.start = 1'b1;
      end
      ST_X2:   short_re = 1'b1;
      ST_SUPD: short_we = 1'b1;
      ST_SDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(ssum);
        div_req.divisor  = DIVISOR_W'(s_eff);
      end
      ST_OUT:  out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_thr     <= JUMP_THR_RST;
      long_len     <= LONG_LEN_RST;
      short_len    <= SHORT_LEN_RST;
      analysis_len <= ANALYSIS_LEN_RST;
      jump_offset  <= '0;
      prev         <= '0;
      have_prev    <= 1'b0;
      lfill        <= '0;
      lptr         <= '0;
      lsum         <= '0;
      sfill        <= '0;
      sptr         <= '0;
      ssum         <= '0;
      pc           <= '0;
      ready_flag   <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tuser      <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_JUMP: begin
          prev <= sample;
          if (have_prev) begin
            if (THR_W'(mag) > jump_thr) begin
              jump_offset <= sat24(WIDE_W'(jump_offset) + WIDE_W'(diff));
            end
          end else begin
            have_prev <= 1'b1;
            lfill     <= '0;
            lptr      <= '0;
            lsum      <= '0;
          end
        end
        ST_LUPD: begin
          if (!lfull) begin
            lfill <= lfill_inc;
          end
          lsum <= lsum + LSUM_W'(x1)
                  - (lfull ? LSUM_W'($signed(long_rdata)) : LSUM_W'(0));
          lptr <= (lptr_inc == l_eff) ? '0 : lptr_inc;
          if (!lfull_next) begin
            sfill <= '0;
            sptr  <= '0;
            ssum  <= '0;
          end
        end
        ST_SUPD: begin
          if (!sfull) begin
            sfill <= sfill_inc;
          end
          ssum <= ssum + SSUM_W'(x2)
                  - (sfull ? SSUM_W'($signed(short_rdata)) : SSUM_W'(0));
          sptr <= (sptr_inc == s_eff) ? '0 : sptr_inc;
          if (!sfull_next) begin
            pc <= '0;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            m_tuser    <= ready_next;
            ready_flag <= ready_next;
            if (pc_open) begin
              pc <= pc_inc;
            end
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_JUMP_THR: jump_thr <= cfg_data[THR_W-1:0];
          REG_LONG_LEN: begin
            long_len <= cfg_data[LLEN_W-1:0];
            lfill    <= '0;
            lptr     <= '0;
            lsum     <= '0;
          end
          REG_SHORT_LEN: begin
            short_len <= cfg_data[SLEN_W-1:0];
            sfill     <= '0;
            sptr      <= '0;
            ssum      <= '0;
          end
          REG_ANALYSIS_LEN: begin
            analysis_len <= cfg_data[ALEN_W-1:0];
            pc           <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sample <= s_tdata;
        end
      end
      ST_JUMP: pass <= !have_prev;
      ST_OFFS: begin
        x1 <= pass ? VALUE_W'(sample)
                   : sat24(WIDE_W'(sample) - WIDE_W'(jump_offset));
      end
      ST_MIDCAP: mid_val <= $signed(long_rdata);
      ST_LDIV: begin
        if (div_rsp.valid) begin
          x2 <= sat24(WIDE_W'(mid_val) - WIDE_W'(div_rsp.quotient));
        end
      end
      ST_SWAIT: begin
        if (div_rsp.valid) begin
          x3 <= sat24(WIDE_W'(div_rsp.quotient));
        end
      end
      ST_OUT: begin
        if (out_load) begin
          m_tdata <= x3;
        end
      end
      default: ;
    endcase
  end

  jrmad_ram #(
    .DEPTH (LONG_DEPTH),
    .WIDTH (VALUE_W)
  ) u_long_ring (
    .clk   (clk),
    .we    (long_we),
    .waddr (LP_W'(lptr)),
    .wdata (x1),
    .re    (long_re),
    .raddr (long_raddr),
    .rdata (long_rdata)
  );

  jrmad_ram #(
    .DEPTH (SHORT_DEPTH),
    .WIDTH (VALUE_W)
  ) u_short_ring (
    .clk   (clk),
    .we    (short_we),
    .waddr (SP_W'(sptr)),
    .wdata (x2),
    .re    (short_re),
    .raddr (SP_W'(sptr)),
    .rdata (short_rdata)
  );

  jrmad_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire

>>> rtl/jrmad_checker.sv
// Port-level checks for the jump-removal detrend filter, bound to its top level.
// Depends on jrmad_pkg for port widths.
`default_nettype none

module jrmad_checker import jrmad_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [VALUE_W-1:0] m_tdata,
  input wire logic               m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample taken while previous one still in work");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle and empty after reset");

  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(m_tuser) |-> m_tuser)
    else $error("window ready flag dropped");

endmodule

bind jump_removal_moving_average_detrend jrmad_checker u_chk (.*);

`default_nettype wire
